// ----- src/cda_pkg.sv -----
// ----------------------------------------------------------------------------
// cda_pkg: calendar date advance types and functions
// Date word type, reset values, month length table, date roll-over and the
// Zeller weekday calculation.
// ----------------------------------------------------------------------------
package cda_pkg;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
  } date_t;

  localparam logic [4:0] HOUR_RST   = 5'd23;
  localparam logic [4:0] HOUR_ZERO  = 5'd0;
  localparam logic [6:0] LAST_YEAR  = 7'd99;
  localparam logic [3:0] LAST_MONTH = 4'd12;
  localparam logic [3:0] FEBRUARY   = 4'd2;
  localparam logic [3:0] MONTH_WRAP = 4'd12;
  localparam logic [2:0] SUNDAY     = 3'd7;
  localparam logic [2:0] CENT_TERM_20 = 3'd6;  // c/4 - 2c - 2 + 2500, mod 7, c = 20
  localparam logic [2:0] CENT_TERM_19 = 3'd7;  // same for c = 19

  localparam date_t DATE_RST = '{year: 7'd18, month: 4'd8, day: 5'd7, weekday: 3'd2};

  function automatic logic [4:0] days_in_month(input logic [6:0] y, input logic [3:0] m);
    logic [4:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
      4'd2:    n = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // floor(26 * (m + 1) / 10) for m = 3..14
  function automatic logic [5:0] month_term(input logic [3:0] m);
    logic [5:0] t;
    unique case (m)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] weekday_of(input logic [6:0] y, input logic [3:0] m,
                                            input logic [4:0] d);
    logic [6:0] yy;
    logic [3:0] mm;
    logic [2:0] ct;
    logic [7:0] s;
    logic [6:0] x;
    logic [3:0] z;
    logic [2:0] w;
    yy = y;
    mm = m;
    ct = CENT_TERM_20;
    if (m <= FEBRUARY) begin
      mm = m + MONTH_WRAP;
      if (y == 7'd0) begin
        yy = LAST_YEAR;
        ct = CENT_TERM_19;
      end else begin
        yy = y - 7'd1;
      end
    end
    s = {1'b0, yy} + {3'b000, yy[6:2]} + {5'b00000, ct} + {2'b00, month_term(mm)}
      + {3'b000, d};
    // fold by 64 and by 8, both are 1 mod 7
    x = {5'b00000, s[7:6]} + {1'b0, s[5:0]};
    z = x[6:3] + {1'b0, x[2:0]};
    if (z >= 4'd14) begin
      w = 3'(z - 4'd14);
    end else if (z >= 4'd7) begin
      w = 3'(z - 4'd7);
    end else begin
      w = z[2:0];
    end
    return (w == 3'd0) ? SUNDAY : w;
  endfunction

  function automatic date_t next_date(input date_t cur);
    logic [5:0] d;
    logic [4:0] m;
    logic [7:0] y;
    date_t r;
    d = {1'b0, cur.day} + 6'd1;
    m = {1'b0, cur.month};
    y = {1'b0, cur.year};
    if (d > {1'b0, days_in_month(cur.year, cur.month)}) begin
      d = 6'd1;
      m = m + 5'd1;
      if (m > {1'b0, LAST_MONTH}) begin
        m = 5'd1;
        y = y + 8'd1;
        if (y > {1'b0, LAST_YEAR}) begin
          y = 8'd0;
        end
      end
    end
    r.year    = y[6:0];
    r.month   = m[3:0];
    r.day     = d[4:0];
    r.weekday = weekday_of(y[6:0], m[3:0], d[4:0]);
    return r;
  endfunction

endpackage

// ----- src/calendar_date_advance.sv -----
// ----------------------------------------------------------------------------
// calendar_date_advance: date counter clocked by hour readings
// Keeps year (2000..2099), month, day and weekday; advances one day when
// the hour reading changes to 0.
// ----------------------------------------------------------------------------
// Each accepted hour word gives exactly one result word. One word is taken
// every cycle while the output is not stalled: the hour goes into an input
// register, and the date roll-over plus the weekday calculation sit between
// that register and the date/result register, which also holds the date
// across output stalls. Reset date is Tuesday 7 Aug 2018 with last hour 23.
module calendar_date_advance
  import cda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] in_hour_reading,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_cur_year,
  output logic [3:0] out_cur_month,
  output logic [4:0] out_cur_day,
  output logic [2:0] out_cur_weekday,
  output logic       out_date_advanced
);

  logic       hour_vld_r;
  logic [4:0] hour_r;
  logic [4:0] prev_hour_r;
  logic [4:0] prev_hour_nxt;
  date_t      date_r;
  date_t      date_nxt;
  logic       adv_r;
  logic       adv_nxt;
  logic       out_valid_r;
  logic       load;

  assign load     = hour_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !hour_vld_r || load;

  always_comb begin
    prev_hour_nxt = prev_hour_r;
    date_nxt      = date_r;
    adv_nxt       = 1'b0;
    if (hour_r != prev_hour_r) begin
      prev_hour_nxt = hour_r;
      if (hour_r == HOUR_ZERO) begin
        date_nxt = next_date(date_r);
        adv_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hour_r <= in_hour_reading;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_hour_r <= HOUR_RST;
      date_r      <= DATE_RST;
      adv_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        hour_vld_r <= in_valid;
      end
      if (load) begin
        out_valid_r <= 1'b1;
        prev_hour_r <= prev_hour_nxt;
        date_r      <= date_nxt;
        adv_r       <= adv_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cur_year      = date_r.year;
  assign out_cur_month     = date_r.month;
  assign out_cur_day       = date_r.day;
  assign out_cur_weekday   = date_r.weekday;
  assign out_date_advanced = adv_r;

  a_adv_on_midnight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_advanced |-> prev_hour_r == HOUR_ZERO)
    else $error("date advanced without hour 0");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    date_r.year <= LAST_YEAR && date_r.month != 4'd0 && date_r.month <= LAST_MONTH
    && date_r.day != 5'd0 && date_r.weekday != 3'd0)
    else $error("date out of range");

  a_hold_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
    load && !adv_nxt |=> $stable(date_r))
    else $error("date changed without advance");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: calendar_date_advance
// Feeds hour words through a valid/ready driver and checks every date word
// against an in-bench calendar predictor. Covers the reset date, repeated
// hours, out-of-range hours, a fast run across two year ends and through
// the 2020 leap day, then clock-like hour runs and random hours, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import cda_pkg::*;

  localparam int STALL_LIMIT = 400;
  localparam int DRAIN       = 10;
  localparam int RANDOM_WORDS = 1750;

  typedef struct packed {
    logic [4:0] prior_hour;
    date_t      date;
    logic       advanced;
  } calendar_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [3:0] gap;
  } hour_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [4:0] in_hour_reading = 5'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_cur_year;
  logic [3:0] out_cur_month;
  logic [4:0] out_cur_day;
  logic [2:0] out_cur_weekday;
  logic       out_date_advanced;

  hour_word_t hour_feed[$];
  int         ready_holds[$];
  calendar_t  due_dates[$];
  calendar_t  cal_now;
  calendar_t  plan_cal;
  calendar_t  want;
  hour_word_t nxt;
  logic       live = 1'b0;
  logic       in_took = 1'b0;
  logic       out_took = 1'b0;
  logic       failed = 1'b0;
  logic       gap_armed = 1'b0;
  int         idle_left = 0;
  int         hold_left = 0;
  int         stuck = 0;
  int         word_count = 0;

  calendar_date_advance u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_hour_reading  (in_hour_reading),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cur_year     (out_cur_year),
    .out_cur_month    (out_cur_month),
    .out_cur_day      (out_cur_day),
    .out_cur_weekday  (out_cur_weekday),
    .out_date_advanced(out_date_advanced)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int month_days(input int y, input int m);
    int n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = (y % 4 == 0) ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] zeller_day(input int y, input int m, input int d);
    int c;
    int s;
    c = 20;
    if (m <= FEBRUARY) begin
      m = m + 12;
      if (y == 0) begin
        y = LAST_YEAR;
        c = 19;
      end else begin
        y = y - 1;
      end
    end
    s = y + y / 4 + c / 4 + 26 * (m + 1) / 10 + d + 2500 - 2 * c - 2;
    return (s % 7 == 0) ? SUNDAY : 3'(s % 7);
  endfunction

  function automatic calendar_t step_calendar(input calendar_t s, input logic [4:0] hour);
    calendar_t n;
    int y;
    int m;
    int d;
    n = s;
    n.advanced = 1'b0;
    if (hour != s.prior_hour) begin
      n.prior_hour = hour;
      if (hour == HOUR_ZERO) begin
        y = s.date.year;
        m = s.date.month;
        d = s.date.day + 1;
        if (d > month_days(y, m)) begin
          d = 1;
          m = m + 1;
          if (m > 12) begin
            m = 1;
            y = (y == LAST_YEAR) ? 0 : y + 1;
          end
        end
        n.date.year    = 7'(y);
        n.date.month   = 4'(m);
        n.date.day     = 5'(d);
        n.date.weekday = zeller_day(y, m, d);
        n.advanced     = 1'b1;
      end
    end
    return n;
  endfunction

  task automatic add_hour(input logic [4:0] hour, input bit idle);
    hour_word_t w;
    w.hour = hour;
    w.gap  = idle ? 4'($urandom_range(0, 11)) : 4'd0;
    hour_feed.push_back(w);
    ready_holds.push_back(idle ? int'($urandom_range(0, 11)) : 0);
    plan_cal = step_calendar(plan_cal, hour);
    word_count++;
  endtask

  task automatic add_burst(input bit quick_only);
    int  kind;
    int  h;
    bit  idle;
    kind = quick_only ? 0 : $urandom_range(0, 3);
    idle = ($urandom_range(0, 3) != 0);
    case (kind)
      0, 1: begin
        // short day: one nonzero hour, then midnight
        h = $urandom_range(1, 31);
        repeat ($urandom_range(1, 3)) add_hour(5'(h), idle);
        repeat ($urandom_range(1, 3)) add_hour(HOUR_ZERO, idle);
      end
      2: begin
        // clock-like run up to midnight
        h = $urandom_range(1, 23);
        while (h < 24) begin
          repeat ($urandom_range(1, 2)) add_hour(5'(h), idle);
          h++;
        end
        add_hour(HOUR_ZERO, idle);
      end
      default: begin
        repeat ($urandom_range(1, 8)) add_hour(5'($urandom_range(0, 31)), idle);
      end
    endcase
  endtask

  initial begin
    cal_now  = '{prior_hour: HOUR_RST, date: DATE_RST, advanced: 1'b0};
    plan_cal = cal_now;

    // repeated reset hour, midnight, repeated midnight, out-of-range hours
    add_hour(5'd23, 1'b1);
    add_hour(5'd0, 1'b1);
    add_hour(5'd0, 1'b1);
    add_hour(5'd31, 1'b1);
    add_hour(5'd31, 1'b0);
    add_hour(5'd0, 1'b0);
    add_hour(5'd24, 1'b1);
    add_hour(5'd16, 1'b1);
    add_hour(5'd8, 1'b0);
    add_hour(5'd4, 1'b1);
    add_hour(5'd2, 1'b0);
    add_hour(5'd1, 1'b1);
    add_hour(5'd0, 1'b1);
    add_hour(5'd23, 1'b0);
    add_hour(5'd0, 1'b0);
    add_hour(5'd21, 1'b1);
    add_hour(5'd10, 1'b1);
    add_hour(5'd0, 1'b1);
    add_hour(5'd0, 1'b0);
    add_hour(5'd30, 1'b1);
    add_hour(5'd0, 1'b1);

    // fast days through the 2020 leap day, no idling
    while (!(plan_cal.date.year == 7'd20 && plan_cal.date.month >= 4'd3)) begin
      add_hour(5'($urandom_range(1, 31)), 1'b0);
      add_hour(HOUR_ZERO, 1'b0);
    end

    while (word_count < RANDOM_WORDS) add_burst(1'b0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (hour_feed.size() != 0 || in_valid || due_dates.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (!failed && due_dates.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hour word driver
  always @(negedge clk) begin
    if (!live) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (hour_feed.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        if (!gap_armed) begin
          idle_left = hour_feed[0].gap;
          gap_armed = 1'b1;
        end
        if (idle_left > 0) begin
          in_valid <= 1'b0;
          idle_left--;
        end else begin
          nxt = hour_feed.pop_front();
          in_hour_reading <= nxt.hour;
          in_valid <= 1'b1;
          gap_armed = 1'b0;
        end
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (!live) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) hold_left = (ready_holds.size() != 0) ? ready_holds.pop_front() : 0;
      out_ready <= (hold_left == 0);
      if (hold_left > 0) hold_left--;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    live     <= rst_n;
    in_took  <= rst_n && in_valid && in_ready;
    out_took <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (due_dates.size() == 0) begin
        $error("date word with nothing expected");
        failed = 1'b1;
      end else begin
        want = due_dates.pop_front();
        if (out_cur_year !== want.date.year) begin
          $error("cur_year: expected %0d, got %0d", want.date.year, out_cur_year);
          failed = 1'b1;
        end
        if (out_cur_month !== want.date.month) begin
          $error("cur_month: expected %0d, got %0d", want.date.month, out_cur_month);
          failed = 1'b1;
        end
        if (out_cur_day !== want.date.day) begin
          $error("cur_day: expected %0d, got %0d", want.date.day, out_cur_day);
          failed = 1'b1;
        end
        if (out_cur_weekday !== want.date.weekday) begin
          $error("cur_weekday: expected %0d, got %0d", want.date.weekday, out_cur_weekday);
          failed = 1'b1;
        end
        if (out_date_advanced !== want.advanced) begin
          $error("date_advanced: expected %0d, got %0d", want.advanced, out_date_advanced);
          failed = 1'b1;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      cal_now = step_calendar(cal_now, in_hour_reading);
      due_dates.push_back(cal_now);
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck <= 0;
    end else if (stuck >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

endmodule
